@@ rtl/qida_pkg.sv @@
// shared types, constants and codes for the query id allocator with quarantine
package qida_pkg;

    // pool size and field widths
    localparam int NUM_IDS = 256;
    localparam int ID_W    = $clog2(NUM_IDS);
    localparam int TIME_W  = 32;
    localparam int HOLD_W  = 15;

    localparam logic [HOLD_W-1:0] HOLD_RESET = 15'd60;

    // request codes
    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_EXH  = 2'd1;
    localparam logic [1:0] STATUS_BAD  = 2'd2;

    // per-id state codes
    localparam logic [1:0] ST_FREE = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    // input word
    typedef struct packed {
        logic              req_type;
        logic [7:0]        release_id;
        logic [TIME_W-1:0] now;
    } in_word_t;

    // output word
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] granted_id;
    } out_word_t;

    // one row of the link table
    typedef struct packed {
        logic [1:0]      id_state;
        logic            last;
        logic [ID_W-1:0] next;
    } node_t;

    // table read address selection
    typedef enum logic [1:0] {
        RD_IN,
        RD_WAIT_HEAD,
        RD_FREE_HEAD,
        RD_TAIL
    } rd_sel_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_RCHK,
        S_FL_RD,
        S_FL_CHK,
        S_POP_RD,
        S_POP,
        S_REL_WR,
        S_TAIL_WR,
        S_DONE
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic       accept;
        logic       rd_en;
        rd_sel_t    rd_sel;
        logic       flush_step;
        logic       pop;
        logic       rel_write;
        logic       tail_write;
        logic       res_set;
        logic [1:0] res_status;
        logic       load_out;
    } ctl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic in_release;
        logic req_release;
        logic free_empty;
        logic wait_empty;
        logic expired;
        logic rd_running;
        logic out_busy;
    } ctl_sts_t;

endpackage

@@ rtl/qida_ctrl.sv @@
// controller state machine sequencing allocate, release and quarantine flush
module qida_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  qida_pkg::ctl_sts_t sts,
    output qida_pkg::ctl_cmd_t cmd
);
    import qida_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.rd_sel     = RD_IN;
        cmd.res_status = STATUS_OK;
        in_stall       = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.in_release)
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_IN;
                        state_next = S_RCHK;
                    end
                    else if (sts.free_empty)
                    begin
                        state_next = S_FL_RD;
                    end
                    else
                    begin
                        state_next = S_POP_RD;
                    end
                end
            end
            // released id must be running
            S_RCHK:
            begin
                if (!sts.rd_running)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = STATUS_BAD;
                    state_next     = S_DONE;
                end
                else
                begin
                    state_next = S_FL_RD;
                end
            end
            // fetch the oldest quarantined id
            S_FL_RD:
            begin
                if (sts.wait_empty)
                begin
                    state_next = sts.req_release ? S_REL_WR : S_POP_RD;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_WAIT_HEAD;
                    state_next = S_FL_CHK;
                end
            end
            // move it to the free list if its hold has run out
            S_FL_CHK:
            begin
                if (sts.expired)
                begin
                    cmd.flush_step = 1'b1;
                    state_next     = S_FL_RD;
                end
                else
                begin
                    state_next = sts.req_release ? S_REL_WR : S_POP_RD;
                end
            end
            S_POP_RD:
            begin
                if (sts.free_empty)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = STATUS_EXH;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_FREE_HEAD;
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                cmd.pop        = 1'b1;
                cmd.res_set    = 1'b1;
                cmd.res_status = STATUS_OK;
                state_next     = S_DONE;
            end
            // queue the id, reading the old tail for relinking
            S_REL_WR:
            begin
                cmd.rel_write = 1'b1;
                if (sts.wait_empty)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = STATUS_OK;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_TAIL;
                    state_next = S_TAIL_WR;
                end
            end
            S_TAIL_WR:
            begin
                cmd.tail_write = 1'b1;
                cmd.res_set    = 1'b1;
                cmd.res_status = STATUS_OK;
                state_next     = S_DONE;
            end
            // hand the result to the output register once it is free
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/qida_dpath.sv @@
// datapath: link table, expiry memory, list pointers, hold register, output register
module qida_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [qida_pkg::HOLD_W-1:0]   cfg_wdata,
    input  qida_pkg::in_word_t            in_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output qida_pkg::out_word_t           out_word,
    input  qida_pkg::ctl_cmd_t            cmd,
    output qida_pkg::ctl_sts_t            sts
);
    import qida_pkg::*;

    // memories
    node_t             node_mem [NUM_IDS];
    logic [TIME_W-1:0] exp_mem  [NUM_IDS];
    logic [NUM_IDS-1:0] node_vld_reg;

    // read side
    node_t             node_rd_reg;
    logic              vld_rd_reg;
    logic [TIME_W-1:0] exp_rd_reg;
    logic [ID_W-1:0]   rd_addr_reg;
    logic [ID_W-1:0]   rd_addr;
    node_t             node_dflt;
    node_t             node_eff;

    // write side
    logic              wr_en;
    logic [ID_W-1:0]   wr_addr;
    node_t             wr_data;

    // list pointers and config
    logic [ID_W-1:0]   free_head_reg;
    logic              free_empty_reg;
    logic [ID_W-1:0]   wait_head_reg;
    logic [ID_W-1:0]   wait_tail_reg;
    logic              wait_empty_reg;
    logic [HOLD_W-1:0] hold_reg;

    // captured request and pending result
    in_word_t          req_reg;
    logic [ID_W-1:0]   req_id;
    logic [1:0]        res_status_reg;
    logic [7:0]        res_grant_reg;
    logic              out_valid_reg;
    out_word_t         out_word_reg;

    logic [TIME_W-1:0] age;

    assign req_id = ID_W'(req_reg.release_id);

    // read address selection
    always_comb
    begin
        case (cmd.rd_sel)
            RD_IN:        rd_addr = ID_W'(in_word.release_id);
            RD_WAIT_HEAD: rd_addr = wait_head_reg;
            RD_FREE_HEAD: rd_addr = free_head_reg;
            RD_TAIL:      rd_addr = wait_tail_reg;
            default:      rd_addr = req_id;
        endcase
    end

    // rows never written read as their reset contents
    always_comb
    begin
        node_dflt.id_state = ST_FREE;
        node_dflt.last     = (rd_addr_reg == ID_W'(NUM_IDS - 1));
        node_dflt.next     = rd_addr_reg + 1'b1;
        node_eff           = vld_rd_reg ? node_rd_reg : node_dflt;
    end

    // table write port
    always_comb
    begin
        wr_en   = cmd.flush_step | cmd.pop | cmd.rel_write | cmd.tail_write;
        wr_addr = cmd.rel_write ? req_id : rd_addr_reg;
        wr_data = node_eff;
        if (cmd.flush_step)
        begin
            wr_data.id_state = ST_FREE;
            wr_data.last     = free_empty_reg;
            wr_data.next     = free_head_reg;
        end
        else if (cmd.pop)
        begin
            wr_data.id_state = ST_RUN;
        end
        else if (cmd.rel_write)
        begin
            wr_data.id_state = ST_WAIT;
            wr_data.last     = 1'b1;
            wr_data.next     = '0;
        end
        else if (cmd.tail_write)
        begin
            wr_data.last = 1'b0;
            wr_data.next = req_id;
        end
    end

    // link table and expiry memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            node_mem[wr_addr] <= wr_data;
        end
        if (cmd.rel_write)
        begin
            exp_mem[req_id] <= req_reg.now + TIME_W'(hold_reg);
        end
        if (cmd.rd_en)
        begin
            node_rd_reg <= node_mem[rd_addr];
            exp_rd_reg  <= exp_mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // row valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_vld_reg <= '0;
            vld_rd_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                node_vld_reg[wr_addr] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                vld_rd_reg <= node_vld_reg[rd_addr];
            end
        end
    end

    // list pointers, hold time, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg  <= '0;
            free_empty_reg <= 1'b0;
            wait_head_reg  <= '0;
            wait_tail_reg  <= '0;
            wait_empty_reg <= 1'b1;
            hold_reg       <= HOLD_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                hold_reg <= cfg_wdata;
            end
            if (cmd.flush_step)
            begin
                free_head_reg  <= rd_addr_reg;
                free_empty_reg <= 1'b0;
                if (node_eff.last)
                begin
                    wait_empty_reg <= 1'b1;
                end
                else
                begin
                    wait_head_reg <= node_eff.next;
                end
            end
            if (cmd.pop)
            begin
                if (node_eff.last)
                begin
                    free_empty_reg <= 1'b1;
                end
                else
                begin
                    free_head_reg <= node_eff.next;
                end
            end
            if (cmd.rel_write)
            begin
                wait_tail_reg <= req_id;
                if (wait_empty_reg)
                begin
                    wait_head_reg  <= req_id;
                    wait_empty_reg <= 1'b0;
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request capture, pending result and output word
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= in_word;
        end
        if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_status;
            res_grant_reg  <= cmd.pop ? 8'(rd_addr_reg) : 8'd0;
        end
        if (cmd.load_out)
        begin
            out_word_reg.status     <= res_status_reg;
            out_word_reg.granted_id <= res_grant_reg;
        end
    end

    // wrap-safe expiry test
    assign age = req_reg.now - exp_rd_reg;

    // status to controller
    always_comb
    begin
        sts.in_release  = (in_word.req_type == REQ_RELEASE);
        sts.req_release = (req_reg.req_type == REQ_RELEASE);
        sts.free_empty  = free_empty_reg;
        sts.wait_empty  = wait_empty_reg;
        sts.expired     = ~age[TIME_W-1];
        sts.rd_running  = (node_eff.id_state == ST_RUN);
        sts.out_busy    = out_valid_reg & out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

@@ rtl/query_id_allocator_quarantine.sv @@
// Accept to output register: an allocate pops the free-list head; a bad release is refused after
// its table read; a release queues the id, relinking the old tail if the quarantine holds ids. An
// allocate on an empty free list adds a quarantine head check if ids wait; each flushed id adds a
// registered table read, then relink; a stalled output holds the finished word in place.
// Throughput: one word at a time; the next word is taken once the result enters the output
// register. Reset clears all pointers and sets hold time to 60; the table reads as reset at once.
module query_id_allocator_quarantine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [qida_pkg::HOLD_W-1:0]   cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  qida_pkg::in_word_t            in_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output qida_pkg::out_word_t           out_word
);
    import qida_pkg::*;

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    // controller
    qida_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    qida_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cmd       (cmd),
        .sts       (sts)
    );

    // one word in flight: after an accept the input stalls
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second word accepted while one is in flight");

    // a result never overwrites one still waiting at the output
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(out_valid && out_stall))
        else $error("output register loaded while stalled");

    // only a successful grant carries a nonzero id
    a_grant_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.status != STATUS_OK) |-> (out_word.granted_id == 8'd0))
        else $error("nonzero id with failing status");

    // status code is one of the three defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.status == STATUS_OK || out_word.status == STATUS_EXH ||
                       out_word.status == STATUS_BAD))
        else $error("undefined status code");

endmodule
